// ----- hdl/ktc_pkg.sv -----
// Shared types and constants for the keyword token classifier.
// Token kind codes, character codes, keyword text and the token record.
// No dependencies.
package ktc_pkg;

   typedef enum logic [4:0] {
      TK_TYPE    = 5'd0,
      TK_STMT    = 5'd1,
      TK_LOOP    = 5'd2,
      TK_RETURN  = 5'd3,
      TK_LITERAL = 5'd4,
      TK_IDENT   = 5'd5,
      TK_LAMBDA  = 5'd6,
      TK_EQUALS  = 5'd7,
      TK_ARITH   = 5'd8,
      TK_COMMA   = 5'd9,
      TK_SEMI    = 5'd10,
      TK_LPAREN  = 5'd11,
      TK_RPAREN  = 5'd12,
      TK_LBRACE  = 5'd13,
      TK_RBRACE  = 5'd14,
      TK_END     = 5'd15,
      TK_ERROR   = 5'd16
   } token_kind_type;

   // one result record
   typedef struct packed {
      logic [7:0]     first_char;
      logic [15:0]    token_len;
      logic [15:0]    start_pos;
      token_kind_type token_kind;
      logic           last_of_run;
   } token_type;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_EOF    = 8'hFF;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   // keyword text, first character in the top byte
   localparam logic [15:0] KW_IF     = "if";
   localparam logic [23:0] KW_INT    = "int";
   localparam logic [23:0] KW_FOR    = "for";
   localparam logic [31:0] KW_CHAR   = "char";
   localparam logic [31:0] KW_ELSE   = "else";
   localparam logic [39:0] KW_FLOAT  = "float";
   localparam logic [39:0] KW_WHILE  = "while";
   localparam logic [47:0] KW_RETURN = "return";

   // single-byte punctuation; TK_ERROR when the byte is none of them
   function automatic token_kind_type single_kind(input logic [7:0] b);
      token_kind_type k;
      unique case (b) inside
         CH_COLON:          k = TK_EQUALS;
         CH_PLUS, CH_MINUS: k = TK_ARITH;
         CH_COMMA:          k = TK_COMMA;
         CH_SEMI:           k = TK_SEMI;
         CH_LPAREN:         k = TK_LPAREN;
         CH_RPAREN:         k = TK_RPAREN;
         CH_LBRACE:         k = TK_LBRACE;
         CH_RBRACE:         k = TK_RBRACE;
         default:           k = TK_ERROR;
      endcase
      return k;
   endfunction

endpackage

// ----- hdl/keyword_token_classifier_top.sv -----
// Keyword token classifier top: one source byte per transaction in, tokens out.
// A byte is registered on input, then its tokens are written into the result queue; a
// second token from the same byte follows the first out of the queue. One byte per cycle
// while the queue has room for two tokens, bounded by the single output port when bytes yield two tokens each.
// Reset (synchronous, active high) clears position and word state and empties the queue.
// Depends on ktc_pkg, ktc_lexer, ktc_out_fifo.
module keyword_token_classifier_top import ktc_pkg::*; #(
   parameter int POS_WIDTH   = 16,
   parameter int KEYWORD_MAX = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [4:0] token_kind, [20:5] start_pos,
                                    // [36:21] token_len, [44:37] first_char
   output logic        rsp_tlast    // last_of_run
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       advance, room_two;
   logic [1:0] tok_count;
   token_type  tok0, tok1, head;

   assign advance    = in_valid_ff && room_two;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   ktc_lexer #(
      .POS_WIDTH   (POS_WIDTH),
      .KEYWORD_MAX (KEYWORD_MAX)
   ) u_lexer (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .char_byte (in_byte_ff),
      .tok0      (tok0),
      .tok1      (tok1),
      .tok_count (tok_count)
   );

   ktc_out_fifo u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_count (advance ? tok_count : 2'd0),
      .wr_data0 (tok0),
      .wr_data1 (tok1),
      .room_two (room_two),
      .rd_valid (rsp_tvalid),
      .rd_ready (rsp_tready),
      .rd_data  (head)
   );

   assign rsp_tdata = {3'b000, head.first_char, head.token_len, head.start_pos,
                       head.token_kind};
   assign rsp_tlast = head.last_of_run;

endmodule

// ----- hdl/ktc_lexer.sv -----
// Lexer state and per-byte token decision for the keyword token classifier.
// Produces up to two tokens per byte from the current state; state updates on step.
// Depends on ktc_pkg.
module ktc_lexer import ktc_pkg::*; #(
   parameter int POS_WIDTH   = 16,
   parameter int KEYWORD_MAX = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] char_byte,
   output token_type  tok0,
   output token_type  tok1,
   output logic [1:0] tok_count
);

   localparam int IDX_W = $clog2(KEYWORD_MAX);

   logic [POS_WIDTH-1:0] position_ff, position_in;
   logic [POS_WIDTH-1:0] word_start_ff, word_start_in;
   logic [POS_WIDTH-1:0] word_length_ff, word_length_in;
   logic                 word_active_ff, word_active_in;
   logic                 first_digit_ff, first_digit_in;
   logic                 pending_ff, pending_in;
   logic                 halted_ff, halted_in;
   logic [7:0]           prefix_ff [KEYWORD_MAX];

   logic                 pre_we;
   logic [IDX_W-1:0]     pre_idx;
   logic [POS_WIDTH-1:0] eff_len;
   logic                 is_digit, is_word, is_space, is_end;
   token_kind_type       word_kind, sk;
   token_type            e0, e1;
   logic                 e0v, e1v, clear_all;
   logic [15:0]          p16, ws16, wl16;
   logic [7:0]           p0, p1, p2, p3, p4, p5;

   function automatic logic [15:0] fit16(input logic [POS_WIDTH-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[15:0];
   endfunction

   assign p16  = fit16(position_ff);
   assign ws16 = fit16(word_start_ff);
   assign wl16 = fit16(word_length_ff);

   assign is_digit = (char_byte >= "0") && (char_byte <= "9");
   assign is_word  = is_digit || ((char_byte >= "A") && (char_byte <= "Z")) ||
                     ((char_byte >= "a") && (char_byte <= "z")) || (char_byte == CH_QUOTE);
   assign is_space = (char_byte == CH_SPACE) || (char_byte == CH_TAB) || (char_byte == CH_LF);
   assign is_end   = (char_byte == CH_NUL) || (char_byte == CH_EOF);
   assign sk       = single_kind(char_byte);

   assign p0 = prefix_ff[0];
   assign p1 = prefix_ff[1];
   assign p2 = prefix_ff[2];
   assign p3 = prefix_ff[3];
   assign p4 = prefix_ff[4];
   assign p5 = prefix_ff[5];

   // keyword match on the stored prefix; a saturated length never matches
   always_comb begin
      word_kind = first_digit_ff ? TK_LITERAL : TK_IDENT;
      if (word_length_ff == POS_WIDTH'(2) && {p0, p1} == KW_IF) begin
         word_kind = TK_STMT;
      end else if (word_length_ff == POS_WIDTH'(3) && {p0, p1, p2} == KW_INT) begin
         word_kind = TK_TYPE;
      end else if (word_length_ff == POS_WIDTH'(3) && {p0, p1, p2} == KW_FOR) begin
         word_kind = TK_LOOP;
      end else if (word_length_ff == POS_WIDTH'(4) && {p0, p1, p2, p3} == KW_CHAR) begin
         word_kind = TK_TYPE;
      end else if (word_length_ff == POS_WIDTH'(4) && {p0, p1, p2, p3} == KW_ELSE) begin
         word_kind = TK_STMT;
      end else if (word_length_ff == POS_WIDTH'(5) && {p0, p1, p2, p3, p4} == KW_FLOAT) begin
         word_kind = TK_TYPE;
      end else if (word_length_ff == POS_WIDTH'(5) && {p0, p1, p2, p3, p4} == KW_WHILE) begin
         word_kind = TK_LOOP;
      end else if (word_length_ff == POS_WIDTH'(6) &&
                   {p0, p1, p2, p3, p4, p5} == KW_RETURN) begin
         word_kind = TK_RETURN;
      end
   end

   always_comb begin
      position_in    = position_ff;
      word_start_in  = word_start_ff;
      word_length_in = word_length_ff;
      word_active_in = word_active_ff;
      first_digit_in = first_digit_ff;
      pending_in     = pending_ff;
      halted_in      = halted_ff;
      e0             = '0;
      e1             = '0;
      e0v            = 1'b0;
      e1v            = 1'b0;
      clear_all      = 1'b0;
      pre_we         = 1'b0;
      eff_len        = word_active_ff ? word_length_ff : '0;
      pre_idx        = eff_len[IDX_W-1:0];

      if (halted_ff) begin
         if (is_end) begin
            e1v       = 1'b1;
            e1        = '{char_byte, 16'd0, p16, TK_END, 1'b0};
            clear_all = 1'b1;
         end else begin
            position_in = position_ff + POS_WIDTH'(1);
         end
      end else if (pending_ff && char_byte == CH_GT) begin
         e1v         = 1'b1;
         e1          = '{CH_EQ, 16'd2, ws16, TK_LAMBDA, 1'b0};
         pending_in  = 1'b0;
         position_in = position_ff + POS_WIDTH'(1);
      end else begin
         position_in = position_ff + POS_WIDTH'(1);
         // a held '=' and an open word never coexist
         if (pending_ff) begin
            e0v        = 1'b1;
            e0         = '{CH_EQ, 16'd1, ws16, TK_EQUALS, 1'b0};
            pending_in = 1'b0;
         end else if (word_active_ff && !is_word) begin
            e0v            = 1'b1;
            e0             = '{p0, wl16, ws16, word_kind, 1'b0};
            word_active_in = 1'b0;
         end

         if (is_word) begin
            if (!word_active_ff) begin
               word_active_in = 1'b1;
               word_start_in  = position_ff;
               first_digit_in = is_digit;
            end
            pre_we = (eff_len < POS_WIDTH'(KEYWORD_MAX));
            if (eff_len != '1) begin
               word_length_in = eff_len + POS_WIDTH'(1);
            end else begin
               word_length_in = eff_len;
            end
         end else if (is_space) begin
            // skipped
         end else if (is_end) begin
            e1v       = 1'b1;
            e1        = '{char_byte, 16'd0, p16, TK_END, 1'b0};
            clear_all = 1'b1;
         end else if (char_byte == CH_EQ) begin
            pending_in    = 1'b1;
            word_start_in = position_ff;
         end else if (sk != TK_ERROR) begin
            e1v = 1'b1;
            e1  = '{char_byte, 16'd1, p16, sk, 1'b0};
         end else begin
            e1v       = 1'b1;
            e1        = '{char_byte, 16'd1, p16, TK_ERROR, 1'b0};
            halted_in = 1'b1;
         end
      end

      if (clear_all) begin
         position_in    = '0;
         word_start_in  = '0;
         word_length_in = '0;
         word_active_in = 1'b0;
         first_digit_in = 1'b0;
         pending_in     = 1'b0;
         halted_in      = 1'b0;
      end
   end

   // pack results into the lowest slots, mark the last one
   always_comb begin
      tok0      = e0v ? e0 : e1;
      tok1      = e1;
      tok_count = 2'(e0v) + 2'(e1v);
      tok0.last_of_run = (tok_count == 2'd1);
      tok1.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         word_start_ff  <= '0;
         word_length_ff <= '0;
         word_active_ff <= 1'b0;
         first_digit_ff <= 1'b0;
         pending_ff     <= 1'b0;
         halted_ff      <= 1'b0;
      end else if (step) begin
         position_ff    <= position_in;
         word_start_ff  <= word_start_in;
         word_length_ff <= word_length_in;
         word_active_ff <= word_active_in;
         first_digit_ff <= first_digit_in;
         pending_ff     <= pending_in;
         halted_ff      <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && pre_we) begin
         prefix_ff[pre_idx] <= char_byte;
      end
   end

endmodule

// ----- hdl/ktc_out_fifo.sv -----
// Result queue for the keyword token classifier: takes up to two tokens a
// cycle, hands out one per transaction. Depends on ktc_pkg.
module ktc_out_fifo import ktc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] wr_count,
   input  token_type  wr_data0,
   input  token_type  wr_data1,
   output logic       room_two,
   output logic       rd_valid,
   input  logic       rd_ready,
   output token_type  rd_data
);

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = PTR_W + 1;

   token_type        mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign pop      = rd_valid && rd_ready;
   assign room_two = (count_ff <= CNT_W'(FIFO_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(wr_count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(wr_count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= wr_data0;
      end
      if (wr_count == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= wr_data1;
      end
   end

endmodule
